// ===== hdl/dnsqe_pkg.sv =====
package dnsqe_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = 6;

    localparam logic [7:0]  DOT_CHAR       = 8'h2E;
    localparam logic [15:0] QCLASS_IN      = 16'd1;
    localparam logic [15:0] QUERY_TYPE_RST = 16'd1;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_CLOSE   = 2'd1,
        ACT_TRAILER = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_LABEL_LEN = 2'd1,
        STAT_NAME_LEN  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_TRL
    } state_t;

    // beat index within the five-byte trailer
    typedef enum logic [2:0] {
        TRL_ZERO    = 3'd0,
        TRL_TYPE_HI = 3'd1,
        TRL_TYPE_LO = 3'd2,
        TRL_CLS_HI  = 3'd3,
        TRL_CLS_LO  = 3'd4
    } trl_beat_t;

endpackage

// ===== hdl/dns_question_name_encoder_top.sv =====
// Encodes a dotted domain name, one byte per input beat, into the wire form of a
// query question: length-prefixed labels, a zero byte, the query type and class 1.
// Name bytes go into a 64-entry label memory, one beat per cycle with no output.
// A dot or a close beat with bytes held and no error sends the label out: its
// length byte, then each held byte, read from the memory one at a time. A trailer
// sends five output beats (one zero byte when in error). Output stalls hold the
// output back. The input is not ready while a label or trailer is being sent out.
module dns_question_name_encoder_top
    import dnsqe_pkg::*;
#(
    parameter int MAX_LABEL = 63,
    parameter int MAX_NAME  = 255
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  in_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_end,
    output logic [1:0]  status,
    output logic [8:0]  question_length,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [7:0] label_mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    state_t              state_reg,  state_next;
    logic [STORE_AW-1:0] idx_reg,    idx_next;
    logic [STORE_AW-1:0] label_cnt_reg, label_cnt_next;
    logic [8:0]          total_reg,  total_next;
    logic [1:0]          err_reg,    err_next;
    logic [1:0]          trl_err_reg, trl_err_next;
    logic [8:0]          trl_qlen_reg, trl_qlen_next;
    logic [2:0]          trl_idx_reg, trl_idx_next;
    logic [15:0]         query_type_reg;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg,  out_byte_next;
    logic                run_end_reg,   run_end_next;
    logic [1:0]          status_reg,    status_next;
    logic [8:0]          qlen_reg,      qlen_next;

    logic                in_fire;
    logic                slot_free;
    logic                load;
    logic                wr_en;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic [9:0]          name_need;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // bytes emitted so far plus held label, the new byte, its length byte and the terminator
    assign name_need = {1'b0, total_reg} + {4'b0, label_cnt_reg} + 10'd3;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        label_cnt_next = label_cnt_reg;
        total_next     = total_reg;
        err_next       = err_reg;
        trl_err_next   = trl_err_reg;
        trl_qlen_next  = trl_qlen_reg;
        trl_idx_next   = trl_idx_reg;
        load           = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        out_byte_next  = out_byte_reg;
        run_end_next   = run_end_reg;
        status_next    = status_reg;
        qlen_next      = qlen_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (action)
                        ACT_BYTE,
                        ACT_CLOSE:
                        begin
                            if (action == ACT_BYTE && in_byte != DOT_CHAR)
                            begin
                                if (err_reg != STAT_OK)
                                begin
                                    err_next = err_reg;
                                end
                                else if (label_cnt_reg >= STORE_AW'(MAX_LABEL))
                                begin
                                    err_next = STAT_LABEL_LEN;
                                end
                                else if (name_need > 10'(MAX_NAME))
                                begin
                                    err_next = STAT_NAME_LEN;
                                end
                                else
                                begin
                                    wr_en          = 1'b1;
                                    label_cnt_next = label_cnt_reg + 1'b1;
                                end
                            end
                            else if (err_reg == STAT_OK && label_cnt_reg != '0)
                            begin
                                total_next = total_reg + {3'b0, label_cnt_reg} + 9'd1;
                                state_next = ST_LEN;
                            end
                        end
                        ACT_TRAILER:
                        begin
                            trl_err_next   = err_reg;
                            trl_qlen_next  = total_reg + 9'd5;
                            trl_idx_next   = TRL_ZERO;
                            label_cnt_next = '0;
                            total_next     = '0;
                            err_next       = STAT_OK;
                            state_next     = ST_TRL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LEN:
            begin
                if (slot_free)
                begin
                    load          = 1'b1;
                    out_byte_next = {{(8-STORE_AW){1'b0}}, label_cnt_reg};
                    run_end_next  = 1'b0;
                    status_next   = STAT_OK;
                    qlen_next     = '0;
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    idx_next      = '0;
                    state_next    = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    load          = 1'b1;
                    out_byte_next = rd_data_reg;
                    status_next   = STAT_OK;
                    qlen_next     = '0;
                    if (idx_reg == label_cnt_reg - 1'b1)
                    begin
                        run_end_next   = 1'b1;
                        label_cnt_next = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        run_end_next = 1'b0;
                        rd_en        = 1'b1;
                        rd_addr      = idx_reg + 1'b1;
                        idx_next     = idx_reg + 1'b1;
                    end
                end
            end
            ST_TRL:
            begin
                if (slot_free)
                begin
                    load         = 1'b1;
                    status_next  = trl_err_reg;
                    qlen_next    = '0;
                    run_end_next = 1'b0;
                    trl_idx_next = trl_idx_reg + 1'b1;
                    if (trl_err_reg != STAT_OK)
                    begin
                        out_byte_next = 8'h00;
                        run_end_next  = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        case (trl_idx_reg)
                            TRL_ZERO:    out_byte_next = 8'h00;
                            TRL_TYPE_HI: out_byte_next = query_type_reg[15:8];
                            TRL_TYPE_LO: out_byte_next = query_type_reg[7:0];
                            TRL_CLS_HI:  out_byte_next = QCLASS_IN[15:8];
                            TRL_CLS_LO:
                            begin
                                out_byte_next = QCLASS_IN[7:0];
                                run_end_next  = 1'b1;
                                qlen_next     = trl_qlen_reg;
                                state_next    = ST_IDLE;
                            end
                            default:
                            begin
                                out_byte_next = 8'h00;
                                state_next    = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            label_cnt_reg  <= '0;
            total_reg      <= '0;
            err_reg        <= STAT_OK;
            out_valid_reg  <= 1'b0;
            query_type_reg <= QUERY_TYPE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            label_cnt_reg <= label_cnt_next;
            total_reg     <= total_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                query_type_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        trl_err_reg  <= trl_err_next;
        trl_qlen_reg <= trl_qlen_next;
        trl_idx_reg  <= trl_idx_next;
        out_byte_reg <= out_byte_next;
        run_end_reg  <= run_end_next;
        status_reg   <= status_next;
        qlen_reg     <= qlen_next;
    end

    // label memory, written while collecting, read while flushing
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            label_mem[label_cnt_reg] <= in_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= label_mem[rd_addr];
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign run_end         = run_end_reg;
    assign status          = status_reg;
    assign question_length = qlen_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import dnsqe_pkg::*;

    localparam int LABEL_MAX     = 63;
    localparam int NAME_MAX      = 255;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 40;

    // action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        status_t    stat;
        logic [8:0] qlen;
    } qbyte_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        run_end;
    logic [1:0]  status;
    logic [8:0]  question_length;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // encoder shadow state
    logic [15:0] qtype = QUERY_TYPE_RST;
    logic [7:0]  lbl_mem [STORE_DEPTH];
    int          lbl_len = 0;
    int          name_len = 0;
    status_t     err_code = STAT_OK;
    qbyte_t      question_q [$];

    int n_in = 0;
    int n_out = 0;
    int n_questions = 0;
    int n_cfg = 0;
    int n_err = 0;
    int cycle_cnt;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit rx_hold_req = 1'b0;

    dns_question_name_encoder_top #(
        .MAX_LABEL (LABEL_MAX),
        .MAX_NAME  (NAME_MAX)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .in_byte         (in_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .run_end         (run_end),
        .status          (status),
        .question_length (question_length),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("[dns_question_name_encoder_top] ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit enable);
        int r;
        r = $urandom_range(0, 99);
        if (!enable || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == DOT_CHAR)
            c = 8'h2D;
        return c;
    endfunction

    function automatic void push_qbyte(input logic [7:0] d, input logic last,
                                       input logic [8:0] ql);
        qbyte_t e;
        e.data = d;
        e.last = last;
        e.stat = err_code;
        e.qlen = ql;
        question_q.push_back(e);
    endfunction

    function automatic void encode_beat(input logic [1:0] act, input logic [7:0] b);
        if (act == ACT_BYTE && b != DOT_CHAR)
        begin
            if (err_code == STAT_OK)
            begin
                // label length is checked before the name length
                if (lbl_len >= LABEL_MAX)
                    err_code = STAT_LABEL_LEN;
                else if (name_len + lbl_len + 3 > NAME_MAX)
                    err_code = STAT_NAME_LEN;
                else
                begin
                    lbl_mem[lbl_len] = b;
                    lbl_len++;
                end
            end
        end
        else if (act == ACT_BYTE || act == ACT_CLOSE)
        begin
            if (err_code == STAT_OK && lbl_len != 0)
            begin
                push_qbyte(8'(lbl_len), 1'b0, 9'd0);
                for (int i = 0; i < lbl_len; i++)
                    push_qbyte(lbl_mem[i], i == lbl_len - 1, 9'd0);
                name_len += lbl_len + 1;
                lbl_len = 0;
            end
        end
        else if (act == ACT_TRAILER)
        begin
            n_questions++;
            if (err_code != STAT_OK)
                push_qbyte(8'h00, 1'b1, 9'd0);
            else
            begin
                // held label bytes are dropped here
                push_qbyte(8'h00, 1'b0, 9'd0);
                push_qbyte(qtype[15:8], 1'b0, 9'd0);
                push_qbyte(qtype[7:0], 1'b0, 9'd0);
                push_qbyte(QCLASS_IN[15:8], 1'b0, 9'd0);
                push_qbyte(QCLASS_IN[7:0], 1'b1, 9'(name_len + 5));
            end
            lbl_len = 0;
            name_len = 0;
            err_code = STAT_OK;
        end
    endfunction

    task automatic check_field(input string what, input logic [8:0] want,
                               input logic [8:0] got);
        if (got !== want)
        begin
            n_err++;
            if (n_err <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        qbyte_t e;
        if (out_valid === 1'b1 && out_ready === 1'b1)
        begin
            n_out++;
            if (question_q.size() == 0)
            begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("%0t ns: unexpected beat, expected none, got out_byte %0h",
                             $time, out_byte);
            end
            else
            begin
                e = question_q.pop_front();
                check_field("out_byte", 9'(e.data), 9'(out_byte));
                check_field("run_end", 9'(e.last), 9'(run_end));
                check_field("status", 9'(e.stat), 9'(status));
                check_field("question_length", e.qlen, question_length);
            end
        end
    end

    // output side: random stalls plus one long hold-off on request
    initial
    begin : receiver
        int n;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                n = pick_gap(rx_idle_en);
                if (n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
        end
    end

    // valid stays high after the beat until the next call or settle
    task automatic send_beat(input logic [1:0] act, input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_idle_en);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_in++;
        encode_beat(act, b);
    endtask

    task automatic send_label(input int len);
        for (int i = 0; i < len; i++)
            send_beat(ACT_BYTE, name_char());
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (question_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_qtype(input logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        qtype = v;
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_question();
        send_beat(ACT_TRAILER, 8'h00);
        send_beat(ACT_TRAILER, 8'hFF);
        settle();
    endtask

    task automatic test_label_flush();
        send_beat(ACT_BYTE, 8'h61);
        send_beat(ACT_BYTE, DOT_CHAR);
        send_beat(ACT_BYTE, 8'h62);
        send_beat(ACT_CLOSE, 8'hFF);
        send_beat(ACT_TRAILER, 8'h00);
        // empty labels and a close with nothing held
        send_beat(ACT_BYTE, DOT_CHAR);
        send_beat(ACT_BYTE, DOT_CHAR);
        send_beat(ACT_CLOSE, DOT_CHAR);
        send_beat(ACT_BYTE, 8'h00);
        send_beat(ACT_BYTE, 8'hFF);
        send_beat(ACT_UNUSED, 8'h41);
        send_beat(ACT_BYTE, DOT_CHAR);
        send_beat(ACT_BYTE, 8'h7F);
        send_beat(ACT_UNUSED, 8'h80);
        send_beat(ACT_TRAILER, 8'h55);
        settle();
    endtask

    task automatic test_query_type();
        write_qtype(16'hFFFF);
        send_beat(ACT_BYTE, 8'h80);
        send_beat(ACT_TRAILER, 8'hAA);
        settle();
        write_qtype(16'h0000);
        send_beat(ACT_TRAILER, 8'h00);
        settle();
        write_qtype(16'h001C);
    endtask

    task automatic test_label_limit();
        send_label(LABEL_MAX);
        send_beat(ACT_CLOSE, 8'h00);
        send_beat(ACT_TRAILER, 8'h00);
        // one byte past the limit, then everything is dropped until the trailer
        send_label(LABEL_MAX + 1);
        send_beat(ACT_BYTE, 8'h41);
        send_beat(ACT_BYTE, DOT_CHAR);
        send_beat(ACT_CLOSE, 8'h00);
        send_beat(ACT_TRAILER, 8'h00);
        send_beat(ACT_BYTE, 8'h42);
        send_beat(ACT_TRAILER, 8'h00);
        settle();
    endtask

    task automatic test_name_limit();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        // three full labels plus 61 bytes fill the name exactly
        for (int k = 0; k < 3; k++)
        begin
            send_label(LABEL_MAX);
            send_beat(ACT_BYTE, DOT_CHAR);
        end
        send_label(61);
        send_beat(ACT_CLOSE, 8'h00);
        send_beat(ACT_TRAILER, 8'h00);
        for (int k = 0; k < 3; k++)
        begin
            send_label(LABEL_MAX);
            send_beat(ACT_BYTE, DOT_CHAR);
        end
        send_label(62);
        send_beat(ACT_BYTE, DOT_CHAR);
        send_beat(ACT_TRAILER, 8'h00);
        settle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_hold_req = 1'b1;
        send_label(40);
        send_beat(ACT_BYTE, DOT_CHAR);
        send_label(30);
        send_beat(ACT_CLOSE, 8'hFF);
        send_label(5);
        send_beat(ACT_TRAILER, 8'h00);
        settle();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_names();
        int start;
        int labels;
        int r;
        start = n_in;
        while (n_in - start < 100)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                settle();
                write_qtype(16'($urandom_range(0, 65535)));
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (r < 8)
            begin
                labels = $urandom_range(1, 4);
                for (int k = 0; k < labels; k++)
                begin
                    if (k > 0)
                        send_beat(ACT_BYTE, DOT_CHAR);
                    send_label(($urandom_range(0, 14) == 0) ? $urandom_range(60, 66)
                                                            : $urandom_range(1, 8));
                end
                case ($urandom_range(0, 3))
                    0: send_beat(ACT_CLOSE, 8'($urandom_range(0, 255)));
                    1: send_beat(ACT_BYTE, DOT_CHAR);
                    default: ;
                endcase
                send_beat(ACT_TRAILER, 8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
        send_beat(ACT_TRAILER, 8'h00);
        settle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_BYTE;
        in_byte   = 8'h00;
        cfg_valid = 1'b0;
        cfg_data  = 16'h0000;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_question();
        test_label_flush();
        test_query_type();
        test_label_limit();
        test_name_limit();
        test_backpressure();
        test_random_names();

        repeat (20) @(posedge clk);
        $display("covered %0d input beats, %0d output beats, %0d questions, %0d type writes",
                 n_in, n_out, n_questions, n_cfg);
        $display("label and name limits, empty labels, ignored actions and a long output stall");
        if (n_err == 0)
            $display("[dns_question_name_encoder_top] OK");
        else
            $display("[dns_question_name_encoder_top] ERROR");
        $finish;
    end

endmodule
